FILE: rtl/hsl_to_rgb_converter_assert.svh
// assertion macros for the hsl to rgb converter
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication
`define HSL2RGB_ASSERT_IMPL(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSL2RGB_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/hsl2rgb_pkg.sv
// shared types and constants of the hsl to rgb converter
package hsl2rgb_pkg;

	localparam int HUE_W  = 14;
	localparam int LIG_W  = 7;
	localparam int RGB_W  = 8;
	localparam int CH_NUM = 3;
	localparam int STAGES = 8;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	localparam logic [HUE_W-1:0] HUE_MAX = 14'd10000;
	localparam logic [LIG_W-1:0] LIG_MAX = 7'd100;

	// remainder widths of the reciprocal correction step
	localparam int HUE_REM_W = 15;
	localparam int LIG_REM_W = 8;

	localparam logic [RGB_W-1:0] BYTE_MAX = 8'hFF;

	typedef enum logic [1:0] {
		RGN_RISE,
		RGN_HIGH,
		RGN_FALL,
		RGN_LOW
	} region_t;

endpackage

FILE: rtl/hsl_to_rgb_converter.sv
// hsl to rgb color converter, eight-stage pipeline
//
// channel | handshake            | payload
// hsl     | hsl_valid, hsl_ready | hue_centi, saturation_centi, lightness_pct
// rgb     | rgb_valid, rgb_ready | red_out, green_out, blue_out
//
// one transfer per cycle on each side while the receiver does not stall
// the rate is set by the eight register stages, each taking a new item every cycle it is not held by a stall
// arst_n clears the stage valid bits only
// a full stage holds while the one after it is full and held, bubbles close up on a stall
// a new item is taken whenever any stage is free, also while a result waits
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            hsl_valid,
	output logic                            hsl_ready,
	input  logic [hsl2rgb_pkg::HUE_W-1:0]   hue_centi,
	input  logic [hsl2rgb_pkg::HUE_W-1:0]   saturation_centi,
	input  logic [hsl2rgb_pkg::LIG_W-1:0]   lightness_pct,
	output logic                            rgb_valid,
	input  logic                            rgb_ready,
	output logic [hsl2rgb_pkg::RGB_W-1:0]   red_out,
	output logic [hsl2rgb_pkg::RGB_W-1:0]   green_out,
	output logic [hsl2rgb_pkg::RGB_W-1:0]   blue_out
);
	import hsl2rgb_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int FW = FRAC_BITS + 1;
	localparam int XW = FW + 1;
	localparam int BW = XW + RGB_W - FRAC_BITS;

	localparam logic [63:0] ONE_W        = 64'd1 << FRAC_BITS;
	localparam logic [63:0] THIRD_W      = (ONE_W + 64'd1) / 64'd3;
	localparam logic [63:0] TWO_THIRDS_W = (64'd2 * ONE_W + 64'd1) / 64'd3;
	localparam logic [63:0] HUE_RECIP_W  = (64'd1 << (FRAC_BITS + HUE_W)) / 64'(HUE_MAX);
	localparam logic [63:0] LIG_RECIP_W  = (64'd1 << (FRAC_BITS + LIG_W)) / 64'(LIG_MAX);

	localparam logic [FW-1:0] ONE_FX        = ONE_W[FW-1:0];
	localparam logic [FW-1:0] HALF_FX       = ONE_W[FW:1];
	localparam logic [FW-1:0] THIRD_FX      = THIRD_W[FW-1:0];
	localparam logic [FW-1:0] ONE_LESS_THIRD_FX = ONE_FX - THIRD_FX;
	localparam logic [FW-1:0] TWO_THIRDS_FX = TWO_THIRDS_W[FW-1:0];
	localparam logic [FW-1:0] HUE_RECIP     = HUE_RECIP_W[FW-1:0];
	localparam logic [FW-1:0] LIG_RECIP     = LIG_RECIP_W[FW-1:0];

	function automatic logic [FW+2:0] times6(input logic [FW-1:0] a);
		times6 = {1'b0, a, 2'b00} + {2'b00, a, 1'b0};
	endfunction

	function automatic logic [FW-1:0] centi_fix(input logic [FW-1:0] q0,
			input logic [HUE_W-1:0] v);
		logic [HUE_W+FRAC_BITS-1:0] sh;
		logic [FW+HUE_W-1:0]        qm;
		logic [HUE_REM_W-1:0]       rem;
		sh  = {v, {FRAC_BITS{1'b0}}};
		qm  = q0 * HUE_MAX;
		rem = sh[HUE_REM_W-1:0] - qm[HUE_REM_W-1:0];
		centi_fix = (rem >= HUE_REM_W'(HUE_MAX)) ? q0 + FW'(1) : q0;
	endfunction

	function automatic logic [FW-1:0] wrap_unit(input logic [FW-1:0] a);
		wrap_unit = (a > ONE_FX) ? a - ONE_FX : a;
	endfunction

	function automatic logic [RGB_W-1:0] to_byte(input logic [XW-1:0] x);
		logic [XW+RGB_W-1:0] sc;
		logic [BW-1:0]       hi;
		sc = {x, {RGB_W{1'b0}}} - {{RGB_W{1'b0}}, x};
		hi = sc[XW+RGB_W-1:FRAC_BITS];
		to_byte = (hi > BW'(BYTE_MAX)) ? BYTE_MAX : hi[RGB_W-1:0];
	endfunction

	// valid bits and stage flow control
	logic [STAGES-1:0] valid_q;
	logic [STAGES-1:0] valid_in;
	logic [STAGES-1:0] stage_rdy;

	always_comb begin
		stage_rdy[STAGES-1] = !valid_q[STAGES-1] || rgb_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
		end
	end

	assign valid_in  = {valid_q[STAGES-2:0], hsl_valid};
	assign hsl_ready = stage_rdy[0];
	assign rgb_valid = valid_q[STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < STAGES; k++) begin
				if (stage_rdy[k]) begin
					valid_q[k] <= valid_in[k];
				end
			end
		end
	end

	// stage 1: clamp and reciprocal estimate
	logic [HUE_W-1:0]       hue_c, sat_c;
	logic [LIG_W-1:0]       lig_c;
	logic [HUE_W+FW-1:0]    hue_prod, sat_prod;
	logic [LIG_W+FW-1:0]    lig_prod;

	logic                   white_s1;
	logic [HUE_W-1:0]       hue_c_s1, sat_c_s1;
	logic [LIG_W-1:0]       lig_c_s1;
	logic [FW-1:0]          hue_q0_s1, sat_q0_s1, lig_q0_s1;

	always_comb begin
		hue_c    = (hue_centi > HUE_MAX) ? HUE_MAX : hue_centi;
		sat_c    = (saturation_centi > HUE_MAX) ? HUE_MAX : saturation_centi;
		lig_c    = (lightness_pct > LIG_MAX) ? LIG_MAX : lightness_pct;
		hue_prod = hue_c * HUE_RECIP;
		sat_prod = sat_c * HUE_RECIP;
		lig_prod = lig_c * LIG_RECIP;
	end

	always_ff @(posedge clk) begin
		if (stage_rdy[0]) begin
			white_s1  <= (saturation_centi == '0);
			hue_c_s1  <= hue_c;
			sat_c_s1  <= sat_c;
			lig_c_s1  <= lig_c;
			hue_q0_s1 <= hue_prod[HUE_W +: FW];
			sat_q0_s1 <= sat_prod[HUE_W +: FW];
			lig_q0_s1 <= lig_prod[LIG_W +: FW];
		end
	end

	// stage 2: quotient correction
	logic [LIG_W+FRAC_BITS-1:0] lig_sh;
	logic [FW+LIG_W-1:0]        lig_qm;
	logic [LIG_REM_W-1:0]       lig_rem;

	logic                   white_s2;
	logic [FW-1:0]          h_s2, s_s2, l_s2;

	always_comb begin
		lig_sh  = {lig_c_s1, {FRAC_BITS{1'b0}}};
		lig_qm  = lig_q0_s1 * LIG_MAX;
		lig_rem = lig_sh[LIG_REM_W-1:0] - lig_qm[LIG_REM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (stage_rdy[1]) begin
			white_s2 <= white_s1;
			h_s2     <= centi_fix(hue_q0_s1, hue_c_s1);
			s_s2     <= centi_fix(sat_q0_s1, sat_c_s1);
			l_s2     <= (lig_rem >= LIG_REM_W'(LIG_MAX)) ? lig_q0_s1 + FW'(1) : lig_q0_s1;
		end
	end

	// stage 3: l*s product and channel hues
	logic [2*FW-1:0]        ls_prod;

	logic                   white_s3;
	logic [FW-1:0]          l_s3, s_s3, p_s3;
	logic [FW-1:0]          vh_s3 [CH_NUM];

	assign ls_prod = l_s2 * s_s2;

	always_ff @(posedge clk) begin
		if (stage_rdy[2]) begin
			white_s3        <= white_s2;
			l_s3            <= l_s2;
			s_s3            <= s_s2;
			p_s3            <= ls_prod[F +: FW];
			vh_s3[CH_RED]   <= wrap_unit(h_s2 + THIRD_FX);
			vh_s3[CH_GREEN] <= h_s2;
			vh_s3[CH_BLUE]  <= wrap_unit(h_s2 + ONE_LESS_THIRD_FX);
		end
	end

	// stage 4: v2, region and ramp factor per channel
	logic [FW:0]            v2_sum;
	logic [FW+2:0]          six_vh [CH_NUM];
	logic [FW+2:0]          six_fall [CH_NUM];
	logic [FW+1:0]          three_vh [CH_NUM];
	region_t                rgn [CH_NUM];
	logic [FW-1:0]          t_val [CH_NUM];

	logic                   white_s4;
	logic [FW-1:0]          l_s4, v2_s4;
	region_t                rgn_s4 [CH_NUM];
	logic [FW-1:0]          t_s4 [CH_NUM];

	always_comb begin
		if (l_s3 < HALF_FX) begin
			v2_sum = {1'b0, l_s3} + {1'b0, p_s3};
		end else begin
			v2_sum = {1'b0, l_s3} + {1'b0, s_s3} - {1'b0, p_s3};
		end
		for (int c = 0; c < CH_NUM; c++) begin
			six_vh[c]   = times6(vh_s3[c]);
			six_fall[c] = times6(TWO_THIRDS_FX - vh_s3[c]);
			three_vh[c] = {1'b0, vh_s3[c], 1'b0} + {2'b00, vh_s3[c]};
			t_val[c]    = six_fall[c][FW-1:0];
			if (six_vh[c] < {3'b000, ONE_FX}) begin
				rgn[c]   = RGN_RISE;
				t_val[c] = six_vh[c][FW-1:0];
			end else if ({vh_s3[c], 1'b0} < {1'b0, ONE_FX}) begin
				rgn[c] = RGN_HIGH;
			end else if (three_vh[c] < {1'b0, ONE_FX, 1'b0}) begin
				rgn[c] = RGN_FALL;
			end else begin
				rgn[c] = RGN_LOW;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_rdy[3]) begin
			white_s4 <= white_s3;
			l_s4     <= l_s3;
			v2_s4    <= v2_sum[FW-1:0];
			for (int c = 0; c < CH_NUM; c++) begin
				rgn_s4[c] <= rgn[c];
				t_s4[c]   <= t_val[c];
			end
		end
	end

	// stage 5: v1 and span
	logic [FW:0]            v1_full;
	logic [FW-1:0]          v1_val;

	logic                   white_s5;
	logic [FW-1:0]          v1_s5, v2_s5, d_s5;
	region_t                rgn_s5 [CH_NUM];
	logic [FW-1:0]          t_s5 [CH_NUM];

	assign v1_full = {l_s4, 1'b0} - {1'b0, v2_s4};
	assign v1_val  = v1_full[FW-1:0];

	always_ff @(posedge clk) begin
		if (stage_rdy[4]) begin
			white_s5 <= white_s4;
			v1_s5    <= v1_val;
			v2_s5    <= v2_s4;
			d_s5     <= v2_s4 - v1_val;
			for (int c = 0; c < CH_NUM; c++) begin
				rgn_s5[c] <= rgn_s4[c];
				t_s5[c]   <= t_s4[c];
			end
		end
	end

	// stage 6: ramp products
	logic [2*FW-1:0]        ramp_prod [CH_NUM];

	logic                   white_s6;
	logic [FW-1:0]          v1_s6, v2_s6;
	region_t                rgn_s6 [CH_NUM];
	logic [FW-1:0]          m_s6 [CH_NUM];

	always_comb begin
		for (int c = 0; c < CH_NUM; c++) begin
			ramp_prod[c] = d_s5 * t_s5[c];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_rdy[5]) begin
			white_s6 <= white_s5;
			v1_s6    <= v1_s5;
			v2_s6    <= v2_s5;
			for (int c = 0; c < CH_NUM; c++) begin
				rgn_s6[c] <= rgn_s5[c];
				m_s6[c]   <= ramp_prod[c][F +: FW];
			end
		end
	end

	// stage 7: channel value select
	logic [XW-1:0]          x_val [CH_NUM];

	logic                   white_s7;
	logic [XW-1:0]          x_s7 [CH_NUM];

	always_comb begin
		for (int c = 0; c < CH_NUM; c++) begin
			case (rgn_s6[c]) inside
				RGN_RISE, RGN_FALL: x_val[c] = {1'b0, v1_s6} + {1'b0, m_s6[c]};
				RGN_HIGH:           x_val[c] = {1'b0, v2_s6};
				default:            x_val[c] = {1'b0, v1_s6};
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (stage_rdy[6]) begin
			white_s7 <= white_s6;
			for (int c = 0; c < CH_NUM; c++) begin
				x_s7[c] <= x_val[c];
			end
		end
	end

	// stage 8: byte scaling and output register
	logic                   white_s8;
	logic [RGB_W-1:0]       rgb_s8 [CH_NUM];

	always_ff @(posedge clk) begin
		if (stage_rdy[7]) begin
			white_s8 <= white_s7;
			for (int c = 0; c < CH_NUM; c++) begin
				rgb_s8[c] <= white_s7 ? BYTE_MAX : to_byte(x_s7[c]);
			end
		end
	end

	assign red_out   = rgb_s8[CH_RED];
	assign green_out = rgb_s8[CH_GREEN];
	assign blue_out  = rgb_s8[CH_BLUE];

	`HSL2RGB_ASSERT_NEXT(a_white_capture, clk, arst_n, hsl_valid && hsl_ready && (saturation_centi == '0), white_s1, "zero saturation transfer not flagged")
	`HSL2RGB_ASSERT_IMPL(a_white_out, clk, arst_n, rgb_valid && white_s8, (red_out == BYTE_MAX) && (green_out == BYTE_MAX) && (blue_out == BYTE_MAX), "zero saturation result is not white")
	`HSL2RGB_ASSERT_IMPL(a_span_order, clk, arst_n, valid_q[4] && !white_s5, v1_s5 <= v2_s5, "v1 above v2")

endmodule

FILE: test/hsl_to_rgb_checker.sv
`timescale 1ns / 1ps
// checker for the hsl to rgb converter: watches both channels, predicts and compares
module hsl_to_rgb_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            hsl_valid,
	input  logic                            hsl_ready,
	input  logic [hsl2rgb_pkg::HUE_W-1:0]   hue_centi,
	input  logic [hsl2rgb_pkg::HUE_W-1:0]   saturation_centi,
	input  logic [hsl2rgb_pkg::LIG_W-1:0]   lightness_pct,
	input  logic                            rgb_valid,
	input  logic                            rgb_ready,
	input  logic [hsl2rgb_pkg::RGB_W-1:0]   red_out,
	input  logic [hsl2rgb_pkg::RGB_W-1:0]   green_out,
	input  logic [hsl2rgb_pkg::RGB_W-1:0]   blue_out,
	output int                              mismatches,
	output int                              in_flight
);
	import hsl2rgb_pkg::*;

	localparam logic [63:0] UNIT       = 64'd1 << FRAC_BITS;
	localparam logic [63:0] THIRD      = (UNIT + 64'd1) / 64'd3;
	localparam logic [63:0] TWO_THIRDS = (64'd2 * UNIT + 64'd1) / 64'd3;
	localparam logic [63:0] CENTI_FULL = 64'd10000;
	localparam logic [63:0] PCT_FULL   = 64'd100;
	localparam int          PRINT_MAX  = 20;

	typedef struct packed {
		logic [RGB_W-1:0] red;
		logic [RGB_W-1:0] green;
		logic [RGB_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [HUE_W-1:0] sat;
		logic [LIG_W-1:0] lig;
	} hsl_t;

	rgb_t expected_q[$];
	hsl_t source_q[$];

	function automatic logic [63:0] wrap_turn(logic [63:0] vh);
		if (vh > UNIT) begin
			return vh - UNIT;
		end
		return vh;
	endfunction

	// rising ramp, plateau, falling ramp, floor
	function automatic logic [63:0] channel_level(logic [63:0] v1, logic [63:0] v2,
			logic [63:0] vh);
		logic [63:0] span;
		span = v2 - v1;
		if (64'd6 * vh < UNIT) begin
			return v1 + ((span * 64'd6 * vh) >> FRAC_BITS);
		end
		if (64'd2 * vh < UNIT) begin
			return v2;
		end
		if (64'd3 * vh < 64'd2 * UNIT) begin
			return v1 + ((span * 64'd6 * (TWO_THIRDS - vh)) >> FRAC_BITS);
		end
		return v1;
	endfunction

	function automatic logic [RGB_W-1:0] level_to_byte(logic [63:0] x);
		logic [63:0] b;
		b = (64'd255 * x) >> FRAC_BITS;
		if (b > BYTE_MAX) begin
			return BYTE_MAX;
		end
		return b[RGB_W-1:0];
	endfunction

	function automatic rgb_t predict_rgb(hsl_t px);
		logic [63:0] hue, sat, lig, h, s, l, v1, v2;
		rgb_t res;
		if (px.sat == '0) begin
			res.red = BYTE_MAX;
			res.green = BYTE_MAX;
			res.blue = BYTE_MAX;
			return res;
		end
		hue = (px.hue > CENTI_FULL) ? CENTI_FULL : 64'(px.hue);
		sat = (px.sat > CENTI_FULL) ? CENTI_FULL : 64'(px.sat);
		lig = (px.lig > PCT_FULL) ? PCT_FULL : 64'(px.lig);
		h = (hue * UNIT) / CENTI_FULL;
		s = (sat * UNIT) / CENTI_FULL;
		l = (lig * UNIT) / PCT_FULL;
		if (64'd2 * l < UNIT) begin
			v2 = (l * (UNIT + s)) >> FRAC_BITS;
		end else begin
			v2 = l + s - ((l * s) >> FRAC_BITS);
		end
		v1 = 64'd2 * l - v2;
		res.red = level_to_byte(channel_level(v1, v2, wrap_turn(h + THIRD)));
		res.green = level_to_byte(channel_level(v1, v2, wrap_turn(h)));
		res.blue = level_to_byte(channel_level(v1, v2, wrap_turn(h + UNIT - THIRD)));
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_MAX) begin
			$display("mismatch at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic compare_field(input string name, input logic [RGB_W-1:0] got,
			input logic [RGB_W-1:0] want, input hsl_t src);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d want %0d for hue %0d sat %0d light %0d",
				name, got, want, src.hue, src.sat, src.lig));
		end
	endtask

	always @(posedge clk) begin : watch
		hsl_t in_px;
		hsl_t src;
		rgb_t want;
		rgb_t got;
		if (arst_n) begin
			if (hsl_valid && hsl_ready) begin
				in_px.hue = hue_centi;
				in_px.sat = saturation_centi;
				in_px.lig = lightness_pct;
				expected_q.push_back(predict_rgb(in_px));
				source_q.push_back(in_px);
			end
			if (rgb_valid && rgb_ready) begin
				got.red = red_out;
				got.green = green_out;
				got.blue = blue_out;
				if (expected_q.size() == 0) begin
					report_mismatch("rgb transfer with no color pending");
				end else begin
					want = expected_q.pop_front();
					src = source_q.pop_front();
					compare_field("red", got.red, want.red, src);
					compare_field("green", got.green, want.green, src);
					compare_field("blue", got.blue, want.blue, src);
				end
			end
			in_flight = expected_q.size();
		end
	end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the hsl to rgb converter: stimulus, flow control and verdict
module tb_top;
	import hsl2rgb_pkg::*;

	localparam int FRAC_BITS        = 16;
	localparam int QUIET_LIMIT      = 1000;
	localparam int RANDOM_PER_PHASE = 270;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 hsl_valid = 1'b0;
	logic                 hsl_ready;
	logic [HUE_W-1:0]     hue_centi = '0;
	logic [HUE_W-1:0]     saturation_centi = '0;
	logic [LIG_W-1:0]     lightness_pct = '0;
	logic                 rgb_valid;
	logic                 rgb_ready = 1'b0;
	logic [RGB_W-1:0]     red_out;
	logic [RGB_W-1:0]     green_out;
	logic [RGB_W-1:0]     blue_out;

	int mismatches;
	int in_flight;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int quiet_cycles = 0;

	hsl_to_rgb_converter #(
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.hsl_valid(hsl_valid),
		.hsl_ready(hsl_ready),
		.hue_centi(hue_centi),
		.saturation_centi(saturation_centi),
		.lightness_pct(lightness_pct),
		.rgb_valid(rgb_valid),
		.rgb_ready(rgb_ready),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out)
	);

	hsl_to_rgb_checker #(
		.FRAC_BITS(FRAC_BITS)
	) color_checker (
		.clk(clk),
		.arst_n(arst_n),
		.hsl_valid(hsl_valid),
		.hsl_ready(hsl_ready),
		.hue_centi(hue_centi),
		.saturation_centi(saturation_centi),
		.lightness_pct(lightness_pct),
		.rgb_valid(rgb_valid),
		.rgb_ready(rgb_ready),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.mismatches(mismatches),
		.in_flight(in_flight)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// receiver backpressure
	initial begin
		forever begin
			@(negedge clk);
			rgb_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// no transfer on either side for too long ends the run
	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((hsl_valid && hsl_ready) || (rgb_valid && rgb_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// called and returns at a falling edge, valid left high
	task automatic send_color(input logic [HUE_W-1:0] h, input logic [HUE_W-1:0] s,
			input logic [LIG_W-1:0] l);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			hsl_valid <= 1'b0;
			@(negedge clk);
		end
		hsl_valid <= 1'b1;
		hue_centi <= h;
		saturation_centi <= s;
		lightness_pct <= l;
		@(posedge clk);
		while (!hsl_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		hsl_valid <= 1'b0;
		while (in_flight != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic random_color();
		logic [HUE_W-1:0] h;
		logic [HUE_W-1:0] s;
		logic [LIG_W-1:0] l;
		int pick;
		int hv;
		pick = $urandom_range(0, 19);
		h = HUE_W'($urandom_range(0, 10000));
		s = HUE_W'($urandom_range(1, 10000));
		l = LIG_W'($urandom_range(0, 100));
		if (pick < 2) begin
			h = HUE_W'($urandom_range(0, 16383));
			s = HUE_W'($urandom_range(0, 16383));
			l = LIG_W'($urandom_range(0, 127));
		end else if (pick == 2) begin
			s = '0;
			h = HUE_W'($urandom_range(0, 16383));
			l = LIG_W'($urandom_range(0, 127));
		end else if (pick < 5) begin
			// hue near a sextant edge
			hv = int'($urandom_range(0, 6)) * 10000 / 6 + int'($urandom_range(0, 6)) - 3;
			if (hv < 0) begin
				hv = 0;
			end
			h = HUE_W'(hv);
		end else if (pick == 5) begin
			l = $urandom_range(0, 1) ? LIG_W'($urandom_range(48, 52))
				: ($urandom_range(0, 1) ? LIG_W'(0) : LIG_W'(100));
			s = $urandom_range(0, 1) ? HUE_W'(10000) : HUE_W'($urandom_range(1, 3));
		end
		send_color(h, s, l);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners, white, out of range fields, sextant edges, lightness midpoint
		send_color(14'd0, 14'd0, 7'd0);
		send_color(14'd0, 14'd0, 7'd100);
		send_color(14'd16383, 14'd0, 7'd127);
		send_color(14'd0, 14'd10000, 7'd50);
		send_color(14'd10000, 14'd10000, 7'd50);
		send_color(14'd10000, 14'd10000, 7'd100);
		send_color(14'd10000, 14'd10000, 7'd0);
		send_color(14'd16383, 14'd16383, 7'd127);
		send_color(14'd10001, 14'd10001, 7'd101);
		send_color(14'd1667, 14'd5000, 7'd50);
		send_color(14'd1666, 14'd5000, 7'd50);
		send_color(14'd3333, 14'd7500, 7'd40);
		send_color(14'd5000, 14'd10000, 7'd60);
		send_color(14'd6666, 14'd2500, 7'd25);
		send_color(14'd6667, 14'd2500, 7'd75);
		send_color(14'd8333, 14'd10000, 7'd50);
		send_color(14'd9999, 14'd1, 7'd1);
		send_color(14'd1, 14'd10000, 7'd49);
		send_color(14'd1, 14'd10000, 7'd51);
		send_color(14'd12345, 14'd1, 7'd99);
		send_color(14'd2500, 14'd16383, 7'd100);
		send_color(14'd7500, 14'd9999, 7'd0);
		drain_pipeline();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 77;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 77;
				end
				default: begin
					src_idle_pct = 34;
					sink_stall_pct = 34;
				end
			endcase
			repeat (RANDOM_PER_PHASE) random_color();
			drain_pipeline();
		end

		repeat (4 * STAGES) @(negedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
